// ----- sv/aln_pkg.sv -----
// Shared types and constants for the normalized associated Legendre block.
// Used by the serial arithmetic unit and by the top-level sequencer.
package aln_pkg;

    localparam logic [5:0] MAX_DEGREE = 6'd63;
    localparam logic [44:0] INV_4PI_Q = 45'd22399066950074;
    localparam logic signed [63:0] ONE_Q = 64'sh0001_0000_0000_0000;
    localparam logic signed [63:0] CAP_Q = 64'sh0100_0000_0000_0000;
    localparam logic [63:0] HALF_Q = 64'h0000_8000_0000_0000;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ORDER = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_RROOT
    } alu_op_t;

    typedef struct packed {
        logic               start;
        alu_op_t            op;
        logic signed [63:0] opa;
        logic signed [63:0] opb;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] result;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL,
        AS_MFIN,
        AS_DIV,
        AS_SQRT,
        AS_DONE
    } alu_state_t;

    typedef enum logic [4:0] {
        TS_IDLE,
        TS_XX,
        TS_S,
        TS_SEED,
        TS_CHK1,
        TS_R1,
        TS_M1,
        TS_M2,
        TS_SIGN,
        TS_R2,
        TS_M3,
        TS_M4,
        TS_CHK2,
        TS_F,
        TS_G,
        TS_A1,
        TS_A2,
        TS_PN,
        TS_OUT
    } top_state_t;

endpackage

// ----- sv/aln_alu.sv -----
// Shared bit-serial arithmetic unit: Q48 product, Q48 square root and ratio root.
// Depends on aln_pkg for the request and response types.
module aln_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  aln_pkg::alu_req_t req,
    output aln_pkg::alu_rsp_t rsp
);
    import aln_pkg::*;

    alu_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [64:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] opa_reg, opa_next;
    logic [127:0] rad_reg, rad_next;
    logic neg_reg, neg_next;
    logic signed [63:0] res_reg, res_next;

    logic [63:0] mag_a, mag_b;
    logic [65:0] mul_sum;
    logic [16:0] div_trial, div_diff;
    logic div_bit;
    logic [63:0] div_quot;
    logic [66:0] sq_rem, sq_trial, sq_diff;
    logic sq_bit;
    logic [63:0] sq_root;
    logic [127:0] prod_rnd;
    logic [79:0] prod_q;
    logic [63:0] prod_mag;

    always_comb begin
        mag_a = req.opa[63] ? (~req.opa + 64'd1) : req.opa;
        mag_b = req.opb[63] ? (~req.opb + 64'd1) : req.opb;
        mul_sum = {1'b0, hi_reg} + {2'b00, (lo_reg[0] ? opa_reg : 64'd0)};
        div_trial = {hi_reg[15:0], lo_reg[63]};
        div_bit = (div_trial >= opa_reg[16:0]);
        div_diff = div_trial - opa_reg[16:0];
        div_quot = {lo_reg[62:0], div_bit};
        sq_rem = {hi_reg, rad_reg[127:126]};
        sq_trial = {1'b0, lo_reg, 2'b01};
        sq_bit = (sq_rem >= sq_trial);
        sq_diff = sq_rem - sq_trial;
        sq_root = {lo_reg[62:0], sq_bit};
        prod_rnd = {hi_reg[63:0], lo_reg};
        prod_q = prod_rnd[127:48];
        prod_mag = (prod_q > {16'd0, CAP_Q}) ? CAP_Q : prod_q[63:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            AS_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        OP_MUL:   state_next = AS_MUL;
                        OP_SQRT:  state_next = AS_SQRT;
                        OP_RROOT: state_next = AS_DIV;
                        default:  state_next = AS_IDLE;
                    endcase
                end
            end
            AS_MUL:  if (cnt_reg == 6'd0) state_next = AS_MFIN;
            AS_MFIN: state_next = AS_DONE;
            AS_DIV:  if (cnt_reg == 6'd0) state_next = AS_SQRT;
            AS_SQRT: if (cnt_reg == 6'd0) state_next = AS_DONE;
            AS_DONE: state_next = AS_IDLE;
            default: state_next = AS_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        opa_next = opa_reg;
        rad_next = rad_reg;
        neg_next = neg_reg;
        res_next = res_reg;
        case (state_reg)
            AS_IDLE: begin
                if (req.start) begin
                    cnt_next = 6'd63;
                    case (req.op)
                        OP_MUL: begin
                            neg_next = req.opa[63] ^ req.opb[63];
                            opa_next = mag_a;
                            lo_next = mag_b;
                            hi_next = {1'b0, HALF_Q};
                        end
                        OP_SQRT: begin
                            rad_next = {16'd0, req.opa, 48'd0};
                            hi_next = '0;
                            lo_next = '0;
                        end
                        OP_RROOT: begin
                            opa_next = {50'd0, req.opb[13:0]};
                            lo_next = {6'd0, req.opa[13:0], 44'd0} + {51'd0, req.opb[13:1]};
                            hi_next = '0;
                        end
                        default: begin
                            hi_next = '0;
                        end
                    endcase
                end
            end
            AS_MUL: begin
                hi_next = mul_sum[65:1];
                lo_next = {mul_sum[0], lo_reg[63:1]};
                cnt_next = cnt_reg - 6'd1;
            end
            AS_MFIN: begin
                res_next = neg_reg ? (64'd0 - prod_mag) : prod_mag;
            end
            AS_DIV: begin
                hi_next = {49'd0, (div_bit ? div_diff[15:0] : div_trial[15:0])};
                lo_next = div_quot;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    rad_next = {12'd0, div_quot, 52'd0};
                    hi_next = '0;
                    lo_next = '0;
                    cnt_next = 6'd63;
                end
            end
            AS_SQRT: begin
                hi_next = sq_bit ? sq_diff[64:0] : sq_rem[64:0];
                lo_next = sq_root;
                rad_next = {rad_reg[125:0], 2'b00};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    res_next = sq_root;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        opa_reg <= opa_next;
        rad_reg <= rad_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done = (state_reg == AS_DONE);
    assign rsp.result = res_reg;

endmodule

// ----- sv/assoc_legendre_normalized.sv -----
// Normalized associated Legendre value: sequencer, operand registers and output stage.
// Depends on aln_pkg and on the shared serial unit aln_alu.
// One item at a time is taken. All products, square roots and ratio roots run on a
// single bit-serial unit that resolves one bit per cycle; a ratio root is a division
// followed by a square root. The work for an item grows with its order m and with
// l-m, and an item flagged with a nonzero status goes straight to the output stage.
// The finished result sits in an output register, so the next item can be taken
// while it waits for its transfer.
module assoc_legendre_normalized (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [5:0]         s_degree,
    input  logic [5:0]         s_order,
    input  logic signed [31:0] s_argument,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value,
    output logic [1:0]         m_status
);
    import aln_pkg::*;

    top_state_t state_reg, state_next;
    logic issued_reg, issued_next;
    logic [5:0] l_reg, l_next, m_reg, m_next;
    logic [6:0] k_reg, k_next;
    logic signed [63:0] x_reg, x_next, s_reg, s_next, t_reg, t_next;
    logic signed [63:0] p0_reg, p0_next, p1_reg, p1_next;
    logic signed [63:0] f_reg, f_next, g_reg, g_next, v_reg, v_next;
    logic [1:0] st_reg, st_next;
    logic m_valid_reg, m_valid_next;
    logic signed [31:0] m_value_reg, m_value_next;
    logic [1:0] m_status_reg, m_status_next;

    alu_req_t req;
    alu_rsp_t rsp;

    logic [5:0] deg_in;
    logic [1:0] in_status;
    logic [15:0] ksq, km1sq, msq;
    logic [6:0] km1;
    logic [51:0] seed_rad;
    logic signed [63:0] one_minus, diff, p0_sgn;
    logic [63:0] v_mag, v_rnd;
    logic [42:0] v_sh;
    logic signed [31:0] out_val;
    logic out_free;

    aln_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_comb begin
        deg_in = (s_degree > MAX_DEGREE) ? MAX_DEGREE : s_degree;
        if (s_order > deg_in) begin
            in_status = STATUS_ORDER;
        end else if (s_argument > 32'sd1073741824 || s_argument < -32'sd1073741824) begin
            in_status = STATUS_RANGE;
        end else begin
            in_status = STATUS_OK;
        end
        km1 = k_reg - 7'd1;
        ksq = 16'(k_reg) * 16'(k_reg);
        km1sq = 16'(km1) * 16'(km1);
        msq = 16'(m_reg) * 16'(m_reg);
        seed_rad = 52'({m_reg, 1'b1}) * 52'(INV_4PI_Q);
        one_minus = ONE_Q - rsp.result;
        diff = t_reg - rsp.result;
        p0_sgn = m_reg[0] ? (64'sd0 - p0_reg) : p0_reg;
        v_mag = v_reg[63] ? (64'd0 - v_reg) : v_reg;
        v_rnd = v_mag + 64'd1048576;
        v_sh = v_rnd[63:21];
        if (v_reg[63]) begin
            out_val = (v_sh > 43'h0_8000_0000) ? 32'sh8000_0000 : (32'sd0 - v_sh[31:0]);
        end else begin
            out_val = (v_sh > 43'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : v_sh[31:0];
        end
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE: begin
                if (s_valid) begin
                    state_next = (in_status == STATUS_OK) ? TS_XX : TS_OUT;
                end
            end
            TS_XX:   if (rsp.done) state_next = TS_S;
            TS_S:    if (rsp.done) state_next = TS_SEED;
            TS_SEED: if (rsp.done) state_next = TS_CHK1;
            TS_CHK1: state_next = (k_reg <= {1'b0, m_reg}) ? TS_R1 : TS_SIGN;
            TS_R1:   if (rsp.done) state_next = TS_M1;
            TS_M1:   if (rsp.done) state_next = TS_M2;
            TS_M2:   if (rsp.done) state_next = TS_CHK1;
            TS_SIGN: state_next = (l_reg == m_reg) ? TS_OUT : TS_R2;
            TS_R2:   if (rsp.done) state_next = TS_M3;
            TS_M3:   if (rsp.done) state_next = TS_M4;
            TS_M4:   if (rsp.done) state_next = TS_CHK2;
            TS_CHK2: state_next = (k_reg <= {1'b0, l_reg}) ? TS_F : TS_OUT;
            TS_F:    if (rsp.done) state_next = TS_G;
            TS_G:    if (rsp.done) state_next = TS_A1;
            TS_A1:   if (rsp.done) state_next = TS_A2;
            TS_A2:   if (rsp.done) state_next = TS_PN;
            TS_PN:   if (rsp.done) state_next = TS_CHK2;
            TS_OUT:  if (out_free) state_next = TS_IDLE;
            default: state_next = TS_IDLE;
        endcase
    end

    always_comb begin
        req.op = OP_MUL;
        req.opa = x_reg;
        req.opb = x_reg;
        case (state_reg)
            TS_XX: begin
                req.op = OP_MUL;
                req.opa = x_reg;
                req.opb = x_reg;
            end
            TS_S: begin
                req.op = OP_SQRT;
                req.opa = t_reg;
            end
            TS_SEED: begin
                req.op = OP_SQRT;
                req.opa = 64'(seed_rad);
            end
            TS_R1: begin
                req.op = OP_RROOT;
                req.opa = 64'({k_reg, 1'b0}) - 64'd1;
                req.opb = 64'({k_reg, 1'b0});
            end
            TS_M1: begin
                req.opa = s_reg;
                req.opb = t_reg;
            end
            TS_M2: begin
                req.opa = p0_reg;
                req.opb = t_reg;
            end
            TS_R2: begin
                req.op = OP_RROOT;
                req.opa = 64'({m_reg, 1'b1}) + 64'd2;
                req.opb = 64'd1;
            end
            TS_M3: begin
                req.opa = x_reg;
                req.opb = t_reg;
            end
            TS_M4: begin
                req.opa = t_reg;
                req.opb = p0_reg;
            end
            TS_F: begin
                req.op = OP_RROOT;
                req.opa = 64'({ksq[13:0], 2'b00}) - 64'd1;
                req.opb = 64'(ksq - msq);
            end
            TS_G: begin
                req.op = OP_RROOT;
                req.opa = 64'(km1sq - msq);
                req.opb = 64'({km1sq[13:0], 2'b00}) - 64'd1;
            end
            TS_A1: begin
                req.opa = x_reg;
                req.opb = p1_reg;
            end
            TS_A2: begin
                req.opa = p0_reg;
                req.opb = g_reg;
            end
            TS_PN: begin
                req.opa = t_reg;
                req.opb = f_reg;
            end
            default: begin
                req.op = OP_MUL;
            end
        endcase
        case (state_reg)
            TS_XX, TS_S, TS_SEED, TS_R1, TS_M1, TS_M2, TS_R2, TS_M3, TS_M4,
            TS_F, TS_G, TS_A1, TS_A2, TS_PN: req.start = !issued_reg;
            default: req.start = 1'b0;
        endcase
        s_ready = (state_reg == TS_IDLE);
    end

    always_comb begin
        issued_next = rsp.done ? 1'b0 : (issued_reg | req.start);
        l_next = l_reg;
        m_next = m_reg;
        k_next = k_reg;
        x_next = x_reg;
        s_next = s_reg;
        t_next = t_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        f_next = f_reg;
        g_next = g_reg;
        v_next = v_reg;
        st_next = st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_status_next = m_status_reg;
        case (state_reg)
            TS_IDLE: begin
                if (s_valid) begin
                    l_next = deg_in;
                    m_next = s_order;
                    x_next = {{14{s_argument[31]}}, s_argument, 18'd0};
                    st_next = in_status;
                    v_next = '0;
                end
            end
            TS_XX: begin
                if (rsp.done) t_next = one_minus[63] ? 64'sd0 : one_minus;
            end
            TS_S:    if (rsp.done) s_next = rsp.result;
            TS_SEED: begin
                if (rsp.done) begin
                    p0_next = rsp.result;
                    k_next = 7'd1;
                end
            end
            TS_R1, TS_M1, TS_R2, TS_M3, TS_A1: begin
                if (rsp.done) t_next = rsp.result;
            end
            TS_M2: begin
                if (rsp.done) begin
                    p0_next = rsp.result;
                    k_next = k_reg + 7'd1;
                end
            end
            TS_SIGN: begin
                p0_next = p0_sgn;
                v_next = p0_sgn;
            end
            TS_M4: begin
                if (rsp.done) begin
                    p1_next = rsp.result;
                    k_next = {1'b0, m_reg} + 7'd2;
                end
            end
            TS_CHK2: begin
                v_next = p1_reg;
            end
            TS_F: if (rsp.done) f_next = rsp.result;
            TS_G: if (rsp.done) g_next = rsp.result;
            TS_A2: begin
                if (rsp.done) begin
                    if (diff > CAP_Q) begin
                        t_next = CAP_Q;
                    end else if (diff < -CAP_Q) begin
                        t_next = -CAP_Q;
                    end else begin
                        t_next = diff;
                    end
                end
            end
            TS_PN: begin
                if (rsp.done) begin
                    p0_next = p1_reg;
                    p1_next = rsp.result;
                    k_next = k_reg + 7'd1;
                end
            end
            TS_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = (st_reg == STATUS_OK) ? out_val : 32'sd0;
                    m_status_next = st_reg;
                end
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TS_IDLE;
            issued_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            issued_reg <= issued_next;
            m_valid_reg <= m_valid_next;
        end
        l_reg <= l_next;
        m_reg <= m_next;
        k_reg <= k_next;
        x_reg <= x_next;
        s_reg <= s_next;
        t_reg <= t_next;
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        f_reg <= f_next;
        g_reg <= g_next;
        v_reg <= v_next;
        st_reg <= st_next;
        m_value_reg <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_status = m_status_reg;

endmodule

// ----- tb/sv/assoc_legendre_normalized_tb.sv -----
// Self-checking testbench for assoc_legendre_normalized: directed and random items with
// a bit-exact fixed-point predictor, random idling on both channels and a watchdog.
// Depends on aln_pkg and on the RTL of assoc_legendre_normalized.
module assoc_legendre_normalized_tb;
    import aln_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam longint ARG_ONE = 64'sd1073741824;
    localparam logic [63:0] CAP_MAG = 64'h0100_0000_0000_0000;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } legendre_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [5:0]         s_degree;
    logic [5:0]         s_order;
    logic signed [31:0] s_argument;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_value;
    logic [1:0]         m_status;

    legendre_result_t pending_results[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    int  idle_cycles;
    bit  failed;

    assoc_legendre_normalized u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_degree  (s_degree),
        .s_order   (s_order),
        .s_argument(s_argument),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_status  (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = {64'd0, r | (64'd1 << b)};
            if (c * c <= v) r = c[63:0];
        end
        return r;
    endfunction

    function automatic longint q48_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [127:0] mag;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = {64'd0, ua} * {64'd0, ub} + {64'd0, HALF_Q};
        mag = p >> 48;
        if (mag > {64'd0, CAP_MAG}) mag = {64'd0, CAP_MAG};
        return ((a < 0) != (b < 0)) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint q48_sqrt(longint v);
        logic [127:0] u;
        u = v < 0 ? 128'd0 : {64'd0, v};
        return longint'(floor_root(u << 48));
    endfunction

    function automatic longint q48_ratio_root(longint a, longint b);
        logic [63:0]  q;
        logic [127:0] w;
        q = ((a << 44) + b / 2) / b;
        w = {64'd0, q};
        return longint'(floor_root(w << 52));
    endfunction

    function automatic longint clamp_cap(longint v);
        if (v > longint'(CAP_MAG)) return longint'(CAP_MAG);
        if (v < -longint'(CAP_MAG)) return -longint'(CAP_MAG);
        return v;
    endfunction

    function automatic legendre_result_t legendre_value(logic [5:0] deg, logic [5:0] ord,
                                                        logic signed [31:0] arg);
        legendre_result_t res;
        longint l, m, x, s, p0, p1, v, f, g, d;
        logic [63:0] mag;
        l = deg;
        m = ord;
        res.value = '0;
        if (l > longint'(MAX_DEGREE)) l = MAX_DEGREE;
        if (m > l) begin
            res.status = STATUS_ORDER;
            return res;
        end
        if (longint'(arg) > ARG_ONE || longint'(arg) < -ARG_ONE) begin
            res.status = STATUS_RANGE;
            return res;
        end
        res.status = STATUS_OK;
        x = longint'(arg) * 262144;
        v = ONE_Q - q48_mul(x, x);
        s = q48_sqrt(v);
        p0 = q48_sqrt((2 * m + 1) * longint'(INV_4PI_Q));
        for (longint k = 1; k <= m; k++)
            p0 = q48_mul(p0, q48_mul(s, q48_ratio_root(2 * k - 1, 2 * k)));
        if (m % 2 == 1) p0 = -p0;
        if (l == m) begin
            v = p0;
        end else begin
            p1 = q48_mul(q48_mul(x, q48_ratio_root(2 * m + 3, 1)), p0);
            for (longint k = m + 2; k <= l; k++) begin
                f = q48_ratio_root(4 * k * k - 1, k * k - m * m);
                g = q48_ratio_root((k - 1) * (k - 1) - m * m, 4 * (k - 1) * (k - 1) - 1);
                d = clamp_cap(q48_mul(x, p1) - q48_mul(p0, g));
                p0 = p1;
                p1 = q48_mul(d, f);
            end
            v = p1;
        end
        mag = v < 0 ? -v : v;
        mag = (mag + 64'd1048576) >> 21;
        if (v < 0) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            res.value = -mag[31:0];
        end else begin
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            res.value = mag[31:0];
        end
        return res;
    endfunction

    task automatic send_item(logic [5:0] deg, logic [5:0] ord, logic signed [31:0] arg);
        s_valid    <= 1'b1;
        s_degree   <= deg;
        s_order    <= ord;
        s_argument <= arg;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(legendre_value(deg, ord, arg));
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    function automatic logic signed [31:0] arg_in_range();
        return $signed(32'($urandom_range(32'h8000_0000, 0))) - 32'sd1073741824;
    endfunction

    task automatic test_edges();
        send_item(6'd0, 6'd0, 32'sd0);
        send_item(6'd1, 6'd0, -32'sd1073741824);
        send_item(6'd1, 6'd1, 32'sd1073741824);
        send_item(6'd2, 6'd1, 32'sd536870912);
        send_item(6'd3, 6'd3, -32'sd536870912);
        send_item(6'd63, 6'd0, 32'sd1073741824);
        send_item(6'd63, 6'd63, -32'sd1073741824);
        send_item(6'd63, 6'd62, 32'sd12345678);
        send_item(6'd40, 6'd7, 32'sd900000000);
        send_item(6'd10, 6'd3, arg_in_range());
    endtask

    task automatic test_order_errors();
        send_item(6'd5, 6'd6, 32'sd0);
        send_item(6'd0, 6'd63, 32'sd1073741825);
        send_item(6'd62, 6'd63, -32'sd2147483648);
    endtask

    task automatic test_range_errors();
        send_item(6'd4, 6'd2, 32'sd1073741825);
        send_item(6'd4, 6'd2, -32'sd1073741825);
        send_item(6'd63, 6'd0, 32'sd2147483647);
        send_item(6'd0, 6'd0, -32'sd2147483648);
    endtask

    task automatic test_random_mix(int count);
        logic [5:0] deg;
        logic [5:0] ord;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                deg = 6'($urandom_range(62));
                ord = 6'($urandom_range(63, deg + 1));
                send_item(deg, ord, $signed($urandom));
            end else if (pick < 38) begin
                deg = 6'($urandom);
                ord = 6'($urandom_range(deg));
                send_item(deg, ord, $signed($urandom));
            end else if (pick < 99) begin
                deg = 6'($urandom_range(3));
                ord = 6'($urandom_range(deg));
                send_item(deg, ord, arg_in_range());
            end else begin
                deg = 6'($urandom);
                ord = 6'($urandom_range(deg));
                send_item(deg, ord, arg_in_range());
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        legendre_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer value %0d status %0d",
                         $time, m_value, m_status);
                failed = 1'b1;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_value !== exp_res.value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, exp_res.value, m_value);
                    failed = 1'b1;
                end
                if (m_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, m_status);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("assoc_legendre_normalized_tb failed");
            $finish;
        end
    end

    initial begin
        failed        = 1'b0;
        idle_cycles   = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_degree      = '0;
        s_order       = '0;
        s_argument    = '0;
        m_ready       = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 66;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edges();
        test_order_errors();
        test_range_errors();
        test_random_mix(380);
        send_idle_pct = 66;
        recv_idle_pct = 13;
        test_random_mix(380);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(390);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("assoc_legendre_normalized_tb passed");
        end else begin
            $display("assoc_legendre_normalized_tb failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/aln_pkg.sv
sv/aln_alu.sv
sv/assoc_legendre_normalized.sv
tb/sv/assoc_legendre_normalized_tb.sv
